// ===== hdl/md4c_pkg.sv =====
package md4c_pkg;
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [31:0] K_R2 = 32'h5a827999;
    localparam logic [31:0] K_R3 = 32'h6ed9eba1;
    localparam logic [5:0]  POS_MASK = 6'h3F;

    // configuration register indexes
    localparam logic CFG_KEY_EN  = 1'b0;
    localparam logic CFG_KEY_VAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_KEY, ST_BYTE, ST_PAD, ST_RD, ST_RND, ST_ADD, ST_OUT
    } t_state;

    // compression core phases
    typedef enum logic [1:0] {
        PH_IDLE, PH_RUN, PH_ADD
    } t_phase;

    // control from the sequencer to the compression core
    typedef struct packed {
        logic       start;
    } t_core_ctl;

    typedef struct packed {
        logic       busy;
        logic       done;
    } t_core_sts;

    // message word index for step i of 48
    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [3:0] s;
        s = i[3:0];
        if (i < 6'd16) return s;
        else if (i < 6'd32) return {s[1:0], s[3:2]};
        else return {s[0], s[1], s[2], s[3]};
    endfunction

    function automatic logic [4:0] shift_amt(input logic [5:0] i);
        logic [1:0] j;
        j = i[1:0];
        if (i < 6'd16) begin
            case (j)
                2'd0: return 5'd3;
                2'd1: return 5'd7;
                2'd2: return 5'd11;
                default: return 5'd19;
            endcase
        end else if (i < 6'd32) begin
            case (j)
                2'd0: return 5'd3;
                2'd1: return 5'd5;
                2'd2: return 5'd9;
                default: return 5'd13;
            endcase
        end else begin
            case (j)
                2'd0: return 5'd3;
                2'd1: return 5'd9;
                2'd2: return 5'd11;
                default: return 5'd15;
            endcase
        end
    endfunction
endpackage

// ===== hdl/md4c_core.sv =====
module md4c_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  md4c_pkg::t_core_ctl  i_ctl,
    input  logic                 i_wr_en,
    input  logic [5:0]           i_wr_addr,
    input  logic [7:0]           i_wr_data,
    input  logic                 i_chain_init,
    output md4c_pkg::t_core_sts  o_sts,
    output logic [31:0]          o_fold
);
    import md4c_pkg::*;

    // block buffer as 16 words of 4 byte lanes
    logic [7:0] mem0 [16];
    logic [7:0] mem1 [16];
    logic [7:0] mem2 [16];
    logic [7:0] mem3 [16];
    logic [31:0] r_rd_word;
    logic [3:0]  rd_addr;

    logic [31:0] r_chain [4];
    logic [31:0] r_work [4];
    logic [5:0]  r_step;
    t_phase      r_phase, n_phase;
    logic [31:0] x, y, z, f, addk, sum, rot;
    logic [1:0]  t;
    logic [4:0]  sh;

    assign rd_addr = (r_phase == PH_RUN && r_step != 6'd47) ? msg_index(r_step + 6'd1)
                                                            : msg_index(6'd0);

    // byte-lane write, registered word read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            case (i_wr_addr[1:0])
                2'd0: mem0[i_wr_addr[5:2]] <= i_wr_data;
                2'd1: mem1[i_wr_addr[5:2]] <= i_wr_data;
                2'd2: mem2[i_wr_addr[5:2]] <= i_wr_data;
                default: mem3[i_wr_addr[5:2]] <= i_wr_data;
            endcase
        end
        r_rd_word <= {mem3[rd_addr], mem2[rd_addr], mem1[rd_addr], mem0[rd_addr]};
    end

    // step function
    always_comb begin
        t = 2'd0 - r_step[1:0];
        x = r_work[t + 2'd1];
        y = r_work[t + 2'd2];
        z = r_work[t + 2'd3];
        if (r_step < 6'd16) begin
            f = (x & y) | (~x & z);
            addk = 32'd0;
        end else if (r_step < 6'd32) begin
            f = (x & y) | (x & z) | (y & z);
            addk = K_R2;
        end else begin
            f = x ^ y ^ z;
            addk = K_R3;
        end
        sh = shift_amt(r_step);
        sum = r_work[t] + f + r_rd_word + addk;
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: if (i_ctl.start) n_phase = PH_RUN;
            PH_RUN: if (r_step == 6'd47) n_phase = PH_ADD;
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_step  <= '0;
            r_chain[0] <= IV_A;
            r_chain[1] <= IV_B;
            r_chain[2] <= IV_C;
            r_chain[3] <= IV_D;
            for (int k = 0; k < 4; k++) r_work[k] <= '0;
        end else begin
            r_phase <= n_phase;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_ctl.start) begin
                        r_step  <= '0;
                        for (int k = 0; k < 4; k++) r_work[k] <= r_chain[k];
                    end else if (i_chain_init) begin
                        r_chain[0] <= IV_A;
                        r_chain[1] <= IV_B;
                        r_chain[2] <= IV_C;
                        r_chain[3] <= IV_D;
                    end
                end
                PH_RUN: begin
                    r_work[t] <= rot;
                    r_step <= r_step + 6'd1;
                end
                default: begin
                    for (int k = 0; k < 4; k++) r_chain[k] <= r_chain[k] + r_work[k];
                end
            endcase
        end
    end

    assign o_sts.busy = (r_phase != PH_IDLE) || i_ctl.start;
    assign o_sts.done = (r_phase == PH_ADD);
    assign o_fold = r_chain[0] ^ r_chain[1] ^ r_chain[2] ^ r_chain[3];
endmodule

// ===== hdl/md4_folded_block_checksum.sv =====
// a request is accepted, then written in ST_BYTE; when the key is fed, ST_KEY writes it first
// every 64th byte starts a compression (a read, 48 round steps and a chain add)
// a last request adds padding bytes at one per cycle with their compressions; the
// checksum is registered in ST_OUT after the chain add, later while the previous waits
// input: a new byte is taken only once the last is written; compressions stall input
// reset: synchronous active low; chain words set to the initial values
module md4_folded_block_checksum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // has_byte
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // checksum
);
    import md4c_pkg::*;

    t_state      r_state, n_state;
    t_state      r_resume, resume_nxt;
    logic        r_key_en;
    logic [31:0] r_key;
    logic        r_key_sent;
    logic [60:0] r_total;
    logic [1:0]  r_kcnt;
    logic [7:0]  r_byte;
    logic        r_has, r_last;
    logic [63:0] r_bits;
    logic        r_pad_wrap;
    logic        r_ovalid;
    logic [31:0] r_odata;
    logic [5:0]  pos;
    logic        fin_blk;
    logic        out_free;

    t_core_ctl ctl;
    t_core_sts sts;
    logic        wr_en;
    logic [7:0]  wr_data;
    logic        chain_init;
    logic [31:0] fold;

    assign pos = r_total[5:0] & POS_MASK;

    // length goes in this block when the 0x80 byte fit below 56 or padding wrapped
    assign fin_blk = (r_bits[8:3] < 6'd56) || r_pad_wrap;
    assign out_free = !r_ovalid || m_axis_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_en <= 1'b0;
            r_key    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_EN:  r_key_en <= i_cfg_data[0];
                default:     r_key    <= i_cfg_data;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);

    // byte source selection
    always_comb begin
        wr_en = 1'b0;
        wr_data = r_byte;
        unique case (r_state)
            ST_KEY: begin
                wr_en = 1'b1;
                wr_data = r_key[{r_kcnt, 3'b000} +: 8];
            end
            ST_BYTE: wr_en = r_has;
            ST_PAD: begin
                wr_en = 1'b1;
                if (r_byte == 8'h80) wr_data = 8'h80;
                else if (pos >= 6'd56 && fin_blk) wr_data = r_bits[{pos[2:0], 3'b000} +: 8];
                else wr_data = 8'h00;
            end
            default: wr_en = 1'b0;
        endcase
    end

    assign ctl.start = wr_en && (pos == 6'd63);
    assign chain_init = (r_state == ST_OUT) && out_free;

    // where to continue once a compression finishes
    always_comb begin
        resume_nxt = ST_IDLE;
        case (r_state)
            ST_KEY: resume_nxt = (r_kcnt == 2'd3) ? ST_BYTE : ST_KEY;
            ST_BYTE: resume_nxt = r_last ? ST_PAD : ST_IDLE;
            ST_PAD: resume_nxt = fin_blk ? ST_OUT : ST_PAD;
            default: resume_nxt = ST_IDLE;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid)
                n_state = (r_key_en && !r_key_sent) ? ST_KEY : ST_BYTE;
            ST_KEY: n_state = ctl.start ? ST_RD : ((r_kcnt == 2'd3) ? ST_BYTE : ST_KEY);
            ST_BYTE: n_state = ctl.start ? ST_RD : (r_last ? ST_PAD : ST_IDLE);
            ST_PAD: n_state = ctl.start ? ST_RD : ST_PAD;
            ST_RD: n_state = ST_RND;
            ST_RND: if (sts.done) n_state = ST_ADD;
            ST_ADD: n_state = r_resume;
            ST_OUT: n_state = out_free ? ST_IDLE : ST_OUT;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath registers; r_byte doubles as first pad byte marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_resume <= ST_IDLE;
            r_key_sent <= 1'b0;
            r_total <= '0;
            r_kcnt <= '0;
            r_ovalid <= 1'b0;
            r_has <= 1'b0;
            r_last <= 1'b0;
            r_pad_wrap <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctl.start) r_resume <= resume_nxt;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (wr_en) r_total <= r_total + 61'd1;
            unique case (r_state)
                ST_IDLE: if (s_axis_tvalid) begin
                    r_byte <= s_axis_tdata;
                    r_has  <= s_axis_tuser;
                    r_last <= s_axis_tlast;
                    r_kcnt <= '0;
                    if (r_key_en && !r_key_sent) r_key_sent <= 1'b1;
                end
                ST_KEY: begin
                    r_kcnt <= r_kcnt + 2'd1;
                    if (r_kcnt == 2'd3 && !ctl.start) r_kcnt <= '0;
                end
                ST_BYTE: begin
                    r_has <= 1'b0;
                    if (r_last) begin
                        r_bits <= {r_total + {60'd0, r_has}, 3'b000};
                        r_byte <= 8'h80;
                        r_pad_wrap <= 1'b0;
                    end
                end
                ST_PAD: begin
                    r_byte <= 8'h00;
                    if (ctl.start) r_pad_wrap <= 1'b1;
                end
                ST_OUT: if (out_free) begin
                    r_ovalid <= 1'b1;
                    r_odata <= fold;
                    r_total <= '0;
                    r_key_sent <= 1'b0;
                    r_last <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    md4c_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_wr_en      (wr_en),
        .i_wr_addr    (pos),
        .i_wr_data    (wr_data),
        .i_chain_init (chain_init),
        .o_sts        (sts),
        .o_fold       (fold)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule
